@@ hdl/tcmrd_pkg.sv @@
// Shared types, codes and helpers for the TCM region decoder.
package tcmrd_pkg;

    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned OFFSET_W     = 15;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned DTCM_BYTES_D = 16384;
    localparam int unsigned ITCM_BYTES_D = 32768;

    // Control word bit positions
    localparam int unsigned CTL_DEN_BIT = 16;
    localparam int unsigned CTL_DLD_BIT = 17;
    localparam int unsigned CTL_IEN_BIT = 18;
    localparam int unsigned CTL_ILD_BIT = 19;

    // Region size field: bits 5:1, clamped, region = 512 << n
    localparam int unsigned SIZE_LSB      = 1;
    localparam int unsigned SIZE_W        = 5;
    localparam int unsigned SIZE_MIN      = 3;
    localparam int unsigned SIZE_MAX      = 23;
    localparam int unsigned SIZE_BASE_LOG = 9;

    typedef enum logic [1:0] {
        OP_FETCH = 2'd0,
        OP_LOAD  = 2'd1,
        OP_STORE = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TGT_BUS  = 2'd0,
        TGT_ITCM = 2'd1,
        TGT_DTCM = 2'd2
    } target_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTROL = 2'd0,
        CFG_DTCM_RGN = 2'd1,
        CFG_ITCM_RGN = 2'd2
    } cfg_idx_t;

    // Decoded configuration handed to the router
    typedef struct packed {
        logic              den;
        logic              dld;
        logic              ien;
        logic              ild;
        logic [ADDR_W-1:0] dmask;
        logic [ADDR_W-1:0] dbase;
        logic [ADDR_W-1:0] imask;
    } tcm_cfg_t;

    // Region size minus one from a region word
    function automatic logic [ADDR_W-1:0] region_mask(input logic [ADDR_W-1:0] word);
        logic [SIZE_W-1:0] n;
        logic [5:0]        sh;
        n = word[SIZE_LSB +: SIZE_W];
        if (n < SIZE_W'(SIZE_MIN)) begin
            n = SIZE_W'(SIZE_MIN);
        end
        if (n > SIZE_W'(SIZE_MAX)) begin
            n = SIZE_W'(SIZE_MAX);
        end
        sh = 6'(n) + 6'(SIZE_BASE_LOG);
        region_mask = ~({ADDR_W{1'b1}} << sh);
    endfunction

endpackage

@@ hdl/tcmrd_route.sv @@
// Combinational routing of one access to ITCM, DTCM or the bus.
module tcmrd_route
    import tcmrd_pkg::*;
#(
    parameter int unsigned DTCM_BYTES = DTCM_BYTES_D,
    parameter int unsigned ITCM_BYTES = ITCM_BYTES_D
) (
    input  tcm_cfg_t            cfg,
    input  logic [1:0]          op,
    input  logic [ADDR_W-1:0]   address,
    output logic [1:0]          target,
    output logic [OFFSET_W-1:0] tcm_offset
);

    localparam logic [OFFSET_W-1:0] I_ARR_MASK = OFFSET_W'(ITCM_BYTES - 1);
    localparam logic [OFFSET_W-1:0] D_ARR_MASK = OFFSET_W'(DTCM_BYTES - 1);

    logic in_i;
    logic in_d;
    logic use_i;
    logic use_d;

    assign in_i = (address & ~cfg.imask) == '0;
    assign in_d = (address & ~cfg.dmask) == cfg.dbase;

    always_comb
    begin
        unique case (op_t'(op))
            OP_FETCH:
            begin
                use_i = cfg.ien & ~cfg.ild;
                use_d = 1'b0;
            end
            OP_LOAD:
            begin
                use_i = cfg.ien & ~cfg.ild;
                use_d = cfg.den & ~cfg.dld;
            end
            OP_STORE:
            begin
                use_i = cfg.ien;
                use_d = cfg.den;
            end
            default:
            begin
                use_i = 1'b0;
                use_d = 1'b0;
            end
        endcase
    end

    // ITCM wins where both regions hold the address
    always_comb
    begin
        priority if (use_i && in_i)
        begin
            target     = TGT_ITCM;
            tcm_offset = address[OFFSET_W-1:0] & cfg.imask[OFFSET_W-1:0] & I_ARR_MASK;
        end
        else if (use_d && in_d)
        begin
            target     = TGT_DTCM;
            tcm_offset = address[OFFSET_W-1:0] & cfg.dmask[OFFSET_W-1:0] & D_ARR_MASK;
        end
        else
        begin
            target     = TGT_BUS;
            tcm_offset = '0;
        end
    end

endmodule

@@ hdl/tcm_region_decoder.sv @@
// Top level of the TCM region decoder: config registers and two-stage pipeline.
//
// Routes each CPU access (fetch, load, store) to the instruction TCM, the
// data TCM or the external bus, and gives the byte offset into the chosen
// array (zero for the bus).
// Channels: the input channel carries op and address; the output channel
// carries target and tcm_offset; both use valid/ready and move one beat
// per handshake. The cfg channel writes the control word (index 0), the
// data TCM region word (1) and the instruction TCM region word (2); it is
// always ready, and writes to other indexes are dropped.
// Path: the input register feeds the combinational decode, and the result
// register captures the decode when it is empty or being drained.
// Throughput: one beat per cycle while the receiver keeps ready high, as the
// decode between the two registers is combinational.
// Reset: all three config words clear to zero (both TCMs disabled, so every
// access goes to the bus) and both pipeline stages empty.
// Stall: when the receiver holds ready low the result register holds its
// beat; the input register then fills and in_ready drops until space opens.
module tcm_region_decoder
    import tcmrd_pkg::*;
#(
    parameter int unsigned DTCM_BYTES = DTCM_BYTES_D,
    parameter int unsigned ITCM_BYTES = ITCM_BYTES_D
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [ADDR_W-1:0]    address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           target,
    output logic [OFFSET_W-1:0]  tcm_offset,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    logic [ADDR_W-1:0]   control_reg;
    logic [ADDR_W-1:0]   dtcm_rgn_reg;
    logic [ADDR_W-1:0]   itcm_rgn_reg;

    logic                s1_valid_reg;
    logic [1:0]          s1_op_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;

    logic                out_valid_reg;
    logic [1:0]          target_reg;
    logic [OFFSET_W-1:0] offset_reg;

    tcm_cfg_t            cfg;
    logic [1:0]          target_next;
    logic [OFFSET_W-1:0] offset_next;
    logic                s2_load;

    // Config writes are taken in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= '0;
            dtcm_rgn_reg <= '0;
            itcm_rgn_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CONTROL:  control_reg  <= cfg_data;
                CFG_DTCM_RGN: dtcm_rgn_reg <= cfg_data;
                CFG_ITCM_RGN: itcm_rgn_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Decode the config words into enables and region masks
    always_comb
    begin
        cfg.den   = control_reg[CTL_DEN_BIT];
        cfg.dld   = control_reg[CTL_DLD_BIT];
        cfg.ien   = control_reg[CTL_IEN_BIT];
        cfg.ild   = control_reg[CTL_ILD_BIT];
        cfg.dmask = region_mask(dtcm_rgn_reg);
        cfg.imask = region_mask(itcm_rgn_reg);
        cfg.dbase = dtcm_rgn_reg & ~cfg.dmask;
    end

    // Advance the result register when it is empty or being drained
    assign s2_load  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_load;

    // Stage 1: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg   <= op;
            s1_addr_reg <= address;
        end
    end

    tcmrd_route #(
        .DTCM_BYTES (DTCM_BYTES),
        .ITCM_BYTES (ITCM_BYTES)
    ) u_route (
        .cfg        (cfg),
        .op         (s1_op_reg),
        .address    (s1_addr_reg),
        .target     (target_next),
        .tcm_offset (offset_next)
    );

    // Stage 2: result register, holds its beat while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            target_reg <= target_next;
            offset_reg <= offset_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign target     = target_reg;
    assign tcm_offset = offset_reg;

endmodule
